FILE: rtl/partition_cut_cost_evaluator_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the partition cut cost evaluator.
// Each macro expects signals named clk and rst in the using scope.
// ---------------------------------------------------------------------------
`ifndef PARTITION_CUT_COST_EVALUATOR_CORE_DEFINES_SVH
`define PARTITION_CUT_COST_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define PCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pcc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcc_pkg
// Shared constants, codes and control types of the cut cost evaluator.
// ---------------------------------------------------------------------------
package pcc_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_PAIRS_DEF = 128;

  // Widest node and pair indexes carried in the command word.
  localparam int NODE_IDX_W = 8;
  localparam int PAIR_IDX_W = 10;

  localparam logic [1:0] CMD_FLOW  = 2'd0;
  localparam logic [1:0] CMD_SHARE = 2'd1;
  localparam logic [1:0] CMD_SEP   = 2'd2;
  localparam logic [1:0] CMD_GENE  = 2'd3;

  localparam logic [2:0] REG_NODE_COUNT   = 3'd0;
  localparam logic [2:0] REG_MAX_CLUSTER  = 3'd1;
  localparam logic [2:0] REG_TOTAL_FLOW   = 3'd2;
  localparam logic [2:0] REG_CONSTR_TOTAL = 3'd3;
  localparam logic [2:0] REG_COHAB        = 3'd4;
  localparam logic [2:0] REG_NONCOHAB     = 3'd5;

  typedef struct packed {
    logic                  store;    // item word accepted
    logic                  clear;    // evaluation starts, clear counters
    logic                  sweep;    // node pair sweep step valid
    logic                  row_end;  // last column of a sweep row
    logic                  upper;    // column above row
    logic [NODE_IDX_W-1:0] a;
    logic [NODE_IDX_W-1:0] b;
    logic                  pair;     // constraint pair step valid
    logic                  sep;      // 1: separate list, 0: share list
    logic [PAIR_IDX_W-1:0] p;
    logic                  mul;      // latch groups and weight product
    logic                  load;     // load result register
  } ctl_cmd_t;

endpackage

FILE: rtl/pcc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcc_ctrl
// Sequencer: load phase, node pair sweep, pair list walks, result hand-off.
// ---------------------------------------------------------------------------
`include "partition_cut_cost_evaluator_core_defines.svh"

module pcc_ctrl #(
  parameter int MAX_NODES = pcc_pkg::MAX_NODES_DEF,
  parameter int MAX_PAIRS = pcc_pkg::MAX_PAIRS_DEF,
  localparam int NW  = $clog2(MAX_NODES),
  localparam int NCW = $clog2(MAX_NODES + 1),
  localparam int PW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1,
  localparam int MCW = $clog2(MAX_PAIRS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [1:0]       item_command,
  input  logic             item_last,
  input  logic [NCW-1:0]   n_eff,
  input  logic [MCW-1:0]   share_m,
  input  logic [MCW-1:0]   sep_m,
  input  logic             out_busy,
  output logic             item_stall,
  output pcc_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_SHARE = 3'd2;
  localparam logic [2:0] S_SEP   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_PROD  = 3'd7;

  logic [2:0]    state, state_next;
  logic [NW-1:0] a, a_next, b, b_next;
  logic [PW-1:0] p, p_next;
  logic [1:0]    drain, drain_next;
  logic          accept, start, row_end, last_row, last_p;
  logic [2:0]    after_sweep, after_share;
  logic [MCW-1:0] m;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign start      = accept && (item_command == pcc_pkg::CMD_GENE) && item_last;
  assign row_end    = (NCW'(b) == n_eff - NCW'(1));
  assign last_row   = (NCW'(a) == n_eff - NCW'(1));
  assign m          = (state == S_SEP) ? sep_m : share_m;
  assign last_p     = (MCW'(p) == m - MCW'(1));

  assign after_share = (sep_m != '0) ? S_SEP : S_DRAIN;
  assign after_sweep = (share_m != '0) ? S_SHARE : after_share;

  always_comb begin
    state_next  = state;
    a_next      = a;
    b_next      = b;
    p_next      = p;
    drain_next  = drain;
    cmd         = '0;
    cmd.store   = accept;
    cmd.clear   = start;
    cmd.a       = pcc_pkg::NODE_IDX_W'(a);
    cmd.b       = pcc_pkg::NODE_IDX_W'(b);
    cmd.p       = pcc_pkg::PAIR_IDX_W'(p);
    cmd.row_end = row_end;
    cmd.upper   = (b > a);
    case (state)
      S_IDLE: begin
        a_next     = '0;
        b_next     = '0;
        p_next     = '0;
        drain_next = '0;
        if (start) begin
          state_next = (n_eff != '0) ? S_SWEEP : after_sweep;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (row_end) begin
          b_next = '0;
          if (last_row) begin
            state_next = after_sweep;
          end else begin
            a_next = a + NW'(1);
          end
        end else begin
          b_next = b + NW'(1);
        end
      end
      S_SHARE: begin
        cmd.pair = 1'b1;
        if (last_p) begin
          p_next     = '0;
          state_next = after_share;
        end else begin
          p_next = p + PW'(1);
        end
      end
      S_SEP: begin
        cmd.pair = 1'b1;
        cmd.sep  = 1'b1;
        if (last_p) begin
          state_next = S_DRAIN;
        end else begin
          p_next = p + PW'(1);
        end
      end
      S_DRAIN: begin
        // drain: memory read plus gene read of the last pair step
        drain_next = drain + 2'd1;
        if (drain == 2'd1) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        // weight product registers here
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      a     <= '0;
      b     <= '0;
      p     <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      a     <= a_next;
      b     <= b_next;
      p     <= p_next;
      drain <= drain_next;
    end
  end

  `PCC_ASSERT_NEXT(a_start_leaves_idle, start, state != S_IDLE, "last gene did not start evaluation")
  `PCC_ASSERT_NOW(a_sweep_in_range, state == S_SWEEP, (NCW'(a) < n_eff) && (NCW'(b) < n_eff), "sweep index past node count")
  `PCC_ASSERT_NEXT(a_done_returns, (state == S_DONE) && !out_busy, state == S_IDLE, "result hand-off did not finish")

endmodule

FILE: rtl/pcc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcc_datapath
// Flow, pair and gene stores, sweep and pair pipelines, cost and result words.
// ---------------------------------------------------------------------------
module pcc_datapath #(
  parameter int MAX_NODES = pcc_pkg::MAX_NODES_DEF,
  parameter int MAX_PAIRS = pcc_pkg::MAX_PAIRS_DEF,
  localparam int NW  = $clog2(MAX_NODES),
  localparam int NCW = $clog2(MAX_NODES + 1),
  localparam int PW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1,
  localparam int MCW = $clog2(MAX_PAIRS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  pcc_pkg::ctl_cmd_t  cmd,
  input  logic [1:0]         command,
  input  logic [5:0]         flow_row,
  input  logic [5:0]         flow_col,
  input  logic signed [15:0] flow_value,
  input  logic [6:0]         pair_index,
  input  logic [5:0]         pair_node_a,
  input  logic [5:0]         pair_node_b,
  input  logic [5:0]         node_index,
  input  logic [5:0]         gene_label,
  input  logic [6:0]         max_cluster_size,
  input  logic [31:0]        total_flow,
  input  logic [2:0]         constraint_total,
  input  logic               result_stall,
  output logic               result_valid,
  output logic [25:0]        intra_flow,
  output logic signed [35:0] normalized_cost,
  output logic [1:0]         violated_groups,
  output logic [6:0]         cluster_count,
  output logic [6:0]         oversize_clusters,
  output logic [7:0]         share_violations,
  output logic [7:0]         separate_violations
);

  localparam int DEPTH_F = 1 << (2 * NW);

  logic [15:0] flow_mem  [DEPTH_F];
  logic [11:0] share_mem [MAX_PAIRS];
  logic [11:0] sep_mem   [MAX_PAIRS];
  logic [5:0]  gene_mem_a [MAX_NODES];
  logic [5:0]  gene_mem_b [MAX_NODES];

  logic flow_we, share_we, sep_we, gene_we;
  assign flow_we  = cmd.store && (command == pcc_pkg::CMD_FLOW) &&
                    (32'(flow_row) < MAX_NODES) && (32'(flow_col) < MAX_NODES);
  assign share_we = cmd.store && (command == pcc_pkg::CMD_SHARE) &&
                    (32'(pair_index) < MAX_PAIRS);
  assign sep_we   = cmd.store && (command == pcc_pkg::CMD_SEP) &&
                    (32'(pair_index) < MAX_PAIRS);
  assign gene_we  = cmd.store && (command == pcc_pkg::CMD_GENE) &&
                    (32'(node_index) < MAX_NODES);

  // Pipeline registers
  logic          sw_v, sw_row_end, sw_upper;
  logic [NW-1:0] sw_a;
  logic          pr1_v, pr1_sep, pr2_v, pr2_sep, pr2_fa, pr2_fb;
  logic [11:0]   share_q, sep_q;
  logic [5:0]    gene_a_q, gene_b_q;
  logic [15:0]   flow_q;
  logic [5:0]    pa, pb;
  logic [NW-1:0] ga_addr, gb_addr;

  assign pa      = pr1_sep ? sep_q[11:6] : share_q[11:6];
  assign pb      = pr1_sep ? sep_q[5:0]  : share_q[5:0];
  assign ga_addr = pr1_v ? NW'(pa) : NW'(cmd.a);
  assign gb_addr = pr1_v ? NW'(pb) : NW'(cmd.b);

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[{NW'(flow_row), NW'(flow_col)}] <= flow_value;
    end
    flow_q <= flow_mem[{NW'(cmd.a), NW'(cmd.b)}];
  end

  always_ff @(posedge clk) begin
    if (share_we) begin
      share_mem[PW'(pair_index)] <= {pair_node_a, pair_node_b};
    end
    share_q <= share_mem[PW'(cmd.p)];
  end

  always_ff @(posedge clk) begin
    if (sep_we) begin
      sep_mem[PW'(pair_index)] <= {pair_node_a, pair_node_b};
    end
    sep_q <= sep_mem[PW'(cmd.p)];
  end

  always_ff @(posedge clk) begin
    if (gene_we) begin
      gene_mem_a[NW'(node_index)] <= gene_label;
    end
    gene_a_q <= gene_mem_a[ga_addr];
  end

  always_ff @(posedge clk) begin
    if (gene_we) begin
      gene_mem_b[NW'(node_index)] <= gene_label;
    end
    gene_b_q <= gene_mem_b[gb_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_v  <= 1'b0;
      pr1_v <= 1'b0;
      pr2_v <= 1'b0;
    end else begin
      sw_v  <= cmd.sweep;
      pr1_v <= cmd.pair;
      pr2_v <= pr1_v;
    end
    sw_row_end <= cmd.row_end;
    sw_upper   <= cmd.upper;
    sw_a       <= NW'(cmd.a);
    pr1_sep    <= cmd.sep;
    pr2_sep    <= pr1_sep;
    pr2_fa     <= (32'(pa) < MAX_NODES);
    pr2_fb     <= (32'(pb) < MAX_NODES);
  end

  // Accumulators
  logic [25:0]    intra;
  logic [NCW-1:0] lbl_cnt, clusters, oversize;
  logic [MCW-1:0] share_v, sep_v;
  logic [1:0]     groups;
  logic signed [36:0] prod;

  logic           match, add_flow, pair_eq;
  logic [26:0]    intra_sum;
  logic [NCW-1:0] lbl_sum;
  logic [5:0]     ga_eff, gb_eff;
  logic signed [3:0] weight;
  logic signed [36:0] cost_full;

  assign match     = sw_v && ((NW + 6)'(gene_b_q) == (NW + 6)'(sw_a));
  assign add_flow  = sw_v && sw_upper && (gene_a_q == gene_b_q) && !flow_q[15];
  assign intra_sum = {1'b0, intra} + 27'(flow_q[14:0]);
  assign lbl_sum   = lbl_cnt + NCW'(match);
  assign ga_eff    = pr2_fa ? gene_a_q : 6'd0;
  assign gb_eff    = pr2_fb ? gene_b_q : 6'd0;
  assign pair_eq   = (ga_eff == gb_eff);
  assign weight    = $signed({1'b0, constraint_total}) - $signed({2'b00, groups});
  assign cost_full = prod + $signed({11'd0, intra});

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      intra    <= '0;
      lbl_cnt  <= '0;
      clusters <= '0;
      oversize <= '0;
      share_v  <= '0;
      sep_v    <= '0;
    end else begin
      if (add_flow) begin
        intra <= intra_sum[26] ? '1 : intra_sum[25:0];
      end
      if (sw_v) begin
        if (sw_row_end) begin
          lbl_cnt <= '0;
          if (lbl_sum != '0) begin
            clusters <= clusters + NCW'(1);
          end
          if (32'(lbl_sum) > 32'(max_cluster_size)) begin
            oversize <= oversize + NCW'(1);
          end
        end else begin
          lbl_cnt <= lbl_sum;
        end
      end
      if (pr2_v && !pr2_sep && !pair_eq) begin
        share_v <= share_v + MCW'(1);
      end
      if (pr2_v && pr2_sep && pair_eq) begin
        sep_v <= sep_v + MCW'(1);
      end
    end
    if (cmd.mul) begin
      groups <= 2'(oversize != '0) + 2'(share_v != '0) + 2'(sep_v != '0);
    end
  end

  // Weight product registered in the cycle after groups settle
  logic mul_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_d <= 1'b0;
    end else begin
      mul_d <= cmd.mul;
    end
    if (mul_d) begin
      prod <= $signed({5'd0, total_flow}) * weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (cmd.load) begin
      intra_flow          <= intra;
      normalized_cost     <= cost_full[35:0];
      violated_groups     <= groups;
      cluster_count       <= 7'(clusters);
      oversize_clusters   <= 7'(oversize);
      share_violations    <= (32'(share_v) > 32'd255) ? 8'd255 : 8'(share_v);
      separate_violations <= (32'(sep_v) > 32'd255) ? 8'd255 : 8'(sep_v);
    end
  end

endmodule

FILE: rtl/partition_cut_cost_evaluator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// partition_cut_cost_evaluator_core
// Scores one graph partition: intra-cluster flow, cluster and pair checks.
// ---------------------------------------------------------------------------
// Usage:
//   Config words (cfg_valid/cfg_ready, cfg_index, cfg_data) set node count,
//   cluster size limit, total flow, group count and pair list lengths; the
//   port is always ready. Write them only while the block is idle.
//   Item words (item_valid/item_stall) load flow entries, share pairs,
//   separate pairs and genes at one word per cycle while item_stall is
//   low. A gene word with last set starts an evaluation; item_stall stays
//   high until it is done. Evaluation order: a sweep over all pairs of the
//   n nodes (n = node count, capped at MAX_NODES), then a walk of the
//   share and separate pairs in use, then drain, product and hand-off.
//   The node pair sweep does one flow memory read per cycle.
//   The result word sits in an output register (result_valid/result_stall);
//   while it waits, new load words are taken, and a further evaluation
//   holds its result until the register is free.
//   Reset (rst, synchronous) restores register defaults and empties the
//   pipeline; stores keep their contents, reading unwritten entries is
//   undefined.
// ---------------------------------------------------------------------------
module partition_cut_cost_evaluator_core #(
  parameter int MAX_NODES = pcc_pkg::MAX_NODES_DEF,
  parameter int MAX_PAIRS = pcc_pkg::MAX_PAIRS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         command,
  input  logic [5:0]         flow_row,
  input  logic [5:0]         flow_col,
  input  logic signed [15:0] flow_value,
  input  logic [6:0]         pair_index,
  input  logic [5:0]         pair_node_a,
  input  logic [5:0]         pair_node_b,
  input  logic [5:0]         node_index,
  input  logic [5:0]         gene_label,
  input  logic               last,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [25:0]        intra_flow,
  output logic signed [35:0] normalized_cost,
  output logic [1:0]         violated_groups,
  output logic [6:0]         cluster_count,
  output logic [6:0]         oversize_clusters,
  output logic [7:0]         share_violations,
  output logic [7:0]         separate_violations
);

  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int MCW = $clog2(MAX_PAIRS + 1);

  // Config registers
  logic [6:0]  node_count, max_cluster_size;
  logic [31:0] total_flow;
  logic [2:0]  constraint_total;
  logic [7:0]  cohab_count, noncohab_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count       <= 7'd64;
      max_cluster_size <= 7'd64;
      total_flow       <= '0;
      constraint_total <= 3'd3;
      cohab_count      <= '0;
      noncohab_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcc_pkg::REG_NODE_COUNT:   node_count       <= cfg_data[6:0];
        pcc_pkg::REG_MAX_CLUSTER:  max_cluster_size <= cfg_data[6:0];
        pcc_pkg::REG_TOTAL_FLOW:   total_flow       <= cfg_data;
        pcc_pkg::REG_CONSTR_TOTAL: constraint_total <= cfg_data[2:0];
        pcc_pkg::REG_COHAB:        cohab_count      <= cfg_data[7:0];
        pcc_pkg::REG_NONCOHAB:     noncohab_count   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective counts, capped at store depths
  logic [NCW-1:0] n_eff;
  logic [MCW-1:0] share_m, sep_m;
  assign n_eff   = (32'(node_count) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count);
  assign share_m = (32'(cohab_count) > MAX_PAIRS) ? MCW'(MAX_PAIRS) : MCW'(cohab_count);
  assign sep_m   = (32'(noncohab_count) > MAX_PAIRS) ? MCW'(MAX_PAIRS) : MCW'(noncohab_count);

  pcc_pkg::ctl_cmd_t cmd;

  pcc_ctrl #(
    .MAX_NODES (MAX_NODES),
    .MAX_PAIRS (MAX_PAIRS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_command (command),
    .item_last    (last),
    .n_eff        (n_eff),
    .share_m      (share_m),
    .sep_m        (sep_m),
    .out_busy     (result_valid && result_stall),
    .item_stall   (item_stall),
    .cmd          (cmd)
  );

  pcc_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_PAIRS (MAX_PAIRS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .command             (command),
    .flow_row            (flow_row),
    .flow_col            (flow_col),
    .flow_value          (flow_value),
    .pair_index          (pair_index),
    .pair_node_a         (pair_node_a),
    .pair_node_b         (pair_node_b),
    .node_index          (node_index),
    .gene_label          (gene_label),
    .max_cluster_size    (max_cluster_size),
    .total_flow          (total_flow),
    .constraint_total    (constraint_total),
    .result_stall        (result_stall),
    .result_valid        (result_valid),
    .intra_flow          (intra_flow),
    .normalized_cost     (normalized_cost),
    .violated_groups     (violated_groups),
    .cluster_count       (cluster_count),
    .oversize_clusters   (oversize_clusters),
    .share_violations    (share_violations),
    .separate_violations (separate_violations)
  );

endmodule
